// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the core RTL file.
// Define NO_ASSERTIONS to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

// ===== hw/rtl/ssfl_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfl_pkg
// Shared types and constants of the substring search core.
// ----------------------------------------------------------------------------
package ssfl_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 16;
    localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
    localparam int COUNT_W       = POSITION_BITS + 1;
    localparam int CHAR_W        = 16;
    localparam int OP_W          = 2;
    localparam int POS_OUT_W     = 16;
    localparam int CFG_ADDR_W    = 3;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT   = 2'd1;
    localparam logic [OP_W-1:0] OP_END    = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Word index of the only register, taken from paddr[2].
    localparam logic REG_SEARCH_REVERSE = 1'b0;

    typedef struct packed {
        logic              text_en;
        logic              append_en;
        logic              clear_en;
        logic              flush_en;
        logic [CHAR_W-1:0] character;
    } cell_ctrl_t;

    typedef struct packed {
        logic                 overflow;
        logic [POS_OUT_W-1:0] position;
        logic                 found;
    } result_t;

endpackage

// ===== hw/rtl/ssfl_cell.sv =====
// ----------------------------------------------------------------------------
// ssfl_cell
// One pattern position: stored code unit, valid bit and partial-match flag.
// ----------------------------------------------------------------------------
module ssfl_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ssfl_pkg::cell_ctrl_t ctrl,
    input  logic                prev_valid,
    input  logic                prev_flag,
    input  logic                next_valid,
    output logic                valid,
    output logic                flag,
    output logic                hit
);

    logic                        valid_reg;
    logic                        valid_next;
    logic                        flag_reg;
    logic                        flag_next;
    logic [ssfl_pkg::CHAR_W-1:0] char_reg;
    logic                        write_here;
    logic                        extend;

    // The first empty cell after the filled ones takes an appended unit.
    assign write_here = ctrl.append_en && prev_valid && !valid_reg;
    assign extend     = prev_flag && (char_reg == ctrl.character);

    always_comb
    begin
        valid_next = valid_reg;
        flag_next  = flag_reg;
        if (ctrl.clear_en)
        begin
            valid_next = 1'b0;
            flag_next  = 1'b0;
        end
        else if (ctrl.flush_en)
        begin
            flag_next = 1'b0;
        end
        else if (write_here)
        begin
            valid_next = 1'b1;
            flag_next  = 1'b0;
        end
        else if (ctrl.text_en && valid_reg)
        begin
            flag_next = extend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_here)
        begin
            char_reg <= ctrl.character;
        end
    end

    // The last filled cell completes a whole-pattern match.
    assign hit   = ctrl.text_en && valid_reg && !next_valid && extend;
    assign valid = valid_reg;
    assign flag  = flag_reg;

endmodule

// ===== hw/rtl/ssfl_out_buf.sv =====
// ----------------------------------------------------------------------------
// ssfl_out_buf
// Result register with a skid stage in front of the master stream side.
// ----------------------------------------------------------------------------
module ssfl_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ssfl_pkg::result_t in_data,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output ssfl_pkg::result_t out_data
);

    logic              out_valid_reg;
    ssfl_pkg::result_t out_data_reg;
    logic              skid_valid_reg;
    ssfl_pkg::result_t skid_data_reg;
    logic              load_out;

    assign load_out = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_valid)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/substring_search_first_or_last_core.sv =====
// ----------------------------------------------------------------------------
// substring_search_first_or_last_core
// Exact 16-bit code unit substring search over a streamed text.
// ----------------------------------------------------------------------------
// Input beats carry an opcode in s_tuser and a code unit in s_tdata: append a
// pattern unit, feed a text unit, end the text, or clear the pattern. Each
// pattern unit sits in one cell of a chain; on every text beat all cells
// update their partial-match flags at once, each from its left neighbor.
// An end-of-text beat gives one result beat on the master side: found flag,
// start position and overflow. search_reverse (APB, offset 0) picks the first
// or the last occurrence.
// Throughput is one input beat per cycle while s_tready is high.
// A result is registered before it appears on m_tvalid.
// When the receiver stalls, the output register holds its result and a skid
// stage takes one more; s_tready then falls until the output drains, so no
// result is lost. Non-result beats keep flowing while the skid stage is empty.
// Reset empties the pattern, clears all text state and sets forward mode;
// pattern units are kept across end-of-text beats until a clear.
// ----------------------------------------------------------------------------
module substring_search_first_or_last_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] character
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] found, [16:1] position, [17] overflow, rest 0
);

    localparam int NCELL = ssfl_pkg::MAX_PATTERN;
    localparam int PB    = ssfl_pkg::POSITION_BITS;
    localparam int CW    = ssfl_pkg::COUNT_W;
    localparam int LW    = ssfl_pkg::LEN_W;

    logic                 search_reverse_reg;
    logic [LW-1:0]        pattern_length_reg;
    logic                 pattern_dropped_reg;
    logic [CW-1:0]        text_count_reg;
    logic                 match_seen_reg;
    logic [PB-1:0]        match_position_reg;
    logic                 overflow_seen_reg;

    logic                 accept;
    logic                 cfg_write;
    ssfl_pkg::cell_ctrl_t ctrl;
    logic [NCELL-1:0]     cell_valid;
    logic [NCELL-1:0]     cell_flag;
    logic [NCELL-1:0]     cell_hit;
    logic                 in_range;
    logic                 hit_any;
    logic [PB-1:0]        start_pos;
    logic                 res_valid;
    ssfl_pkg::result_t    res;
    ssfl_pkg::result_t    out_res;
    logic                 buf_ready;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_reverse_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2] == ssfl_pkg::REG_SEARCH_REVERSE))
        begin
            search_reverse_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == ssfl_pkg::REG_SEARCH_REVERSE) ?
                    {31'b0, search_reverse_reg} : 32'b0;

    // Input decode.
    assign s_tready = buf_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        ctrl.text_en   = accept && (s_tuser == ssfl_pkg::OP_TEXT);
        ctrl.append_en = accept && (s_tuser == ssfl_pkg::OP_APPEND);
        ctrl.clear_en  = accept && (s_tuser == ssfl_pkg::OP_CLEAR);
        ctrl.flush_en  = accept && (s_tuser == ssfl_pkg::OP_END);
        ctrl.character = s_tdata;
    end

    // Cell chain.
    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            logic pv;
            logic pf;
            logic nv;
            if (gi == 0)
            begin : g_first
                assign pv = 1'b1;
                assign pf = 1'b1;
            end
            else
            begin : g_rest
                assign pv = cell_valid[gi-1];
                assign pf = cell_flag[gi-1];
            end
            if (gi == NCELL - 1)
            begin : g_last
                assign nv = 1'b0;
            end
            else
            begin : g_mid
                assign nv = cell_valid[gi+1];
            end
            ssfl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_valid (pv),
                .prev_flag  (pf),
                .next_valid (nv),
                .valid      (cell_valid[gi]),
                .flag       (cell_flag[gi]),
                .hit        (cell_hit[gi])
            );
        end
    endgenerate

    // Text bookkeeping.
    assign in_range  = !text_count_reg[CW-1];
    assign hit_any   = (|cell_hit) && in_range;
    assign start_pos = PB'(text_count_reg + CW'(1) - CW'(pattern_length_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg  <= '0;
            pattern_dropped_reg <= 1'b0;
            text_count_reg      <= '0;
            match_seen_reg      <= 1'b0;
            match_position_reg  <= '0;
            overflow_seen_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.append_en)
            begin
                if (cell_valid[NCELL-1])
                begin
                    pattern_dropped_reg <= 1'b1;
                end
                else
                begin
                    pattern_length_reg <= pattern_length_reg + LW'(1);
                end
            end
            if (ctrl.clear_en)
            begin
                pattern_length_reg  <= '0;
                pattern_dropped_reg <= 1'b0;
            end
            if (ctrl.text_en)
            begin
                if (hit_any)
                begin
                    if (search_reverse_reg || !match_seen_reg)
                    begin
                        match_position_reg <= start_pos;
                    end
                    match_seen_reg <= 1'b1;
                end
                if (in_range)
                begin
                    text_count_reg <= text_count_reg + CW'(1);
                end
                else
                begin
                    overflow_seen_reg <= 1'b1;
                end
            end
            if (ctrl.flush_en)
            begin
                text_count_reg     <= '0;
                match_seen_reg     <= 1'b0;
                match_position_reg <= '0;
                overflow_seen_reg  <= 1'b0;
            end
        end
    end

    // Result of an end-of-text beat.
    always_comb
    begin
        res.overflow = overflow_seen_reg || pattern_dropped_reg;
        if (pattern_length_reg == '0)
        begin
            res.found = 1'b1;
            if (!search_reverse_reg)
            begin
                res.position = '0;
            end
            else if (in_range)
            begin
                res.position = ssfl_pkg::POS_OUT_W'(text_count_reg[PB-1:0]);
            end
            else
            begin
                res.position = ssfl_pkg::POS_OUT_W'({PB{1'b1}});
            end
        end
        else
        begin
            res.found    = match_seen_reg;
            res.position = match_seen_reg ?
                           ssfl_pkg::POS_OUT_W'(match_position_reg) : '0;
        end
    end

    assign res_valid = ctrl.flush_en;

    ssfl_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (buf_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {6'b0, out_res.overflow, out_res.position, out_res.found};

    `include "assert_macros.svh"

    `ASSERT_CLK(a_len_matches_cells, $countones(cell_valid) == 32'(pattern_length_reg), "pattern length disagrees with filled cells")
    `ASSERT_CLK(a_cells_contiguous, cell_valid == NCELL'((({1'b0, cell_valid} << 1) | 1'b1) & {1'b0, cell_valid}), "filled cells are not contiguous")
    `ASSERT_CLK(a_single_hit, $onehot0(cell_hit), "more than one cell completed a match")
    `ASSERT_NEXT(a_end_clears_text, ctrl.flush_en, (text_count_reg == '0) && !match_seen_reg && (cell_flag == '0), "text state not cleared after end of text")
    `ASSERT_CLK(a_stall_blocks_input, !s_tready |-> (m_tvalid && !$past(m_tready) || m_tvalid), "input stalled with no pending result")

endmodule
